// ===== rtl/pfd_pkg.sv =====
// ----------------------------------------------------------------------------
// pfd_pkg
// Shared types, constants and helpers for the Playfair decryption block.
// ----------------------------------------------------------------------------
package pfd_pkg;

  localparam int unsigned CodeW      = 5;
  localparam int unsigned IdxW       = 3;
  localparam int unsigned Cells      = 25;
  localparam int unsigned NumLetters = 26;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [IdxW-1:0]  idx_t;

  localparam code_t CellCount = 5'd25;
  localparam code_t LastCode  = 5'd25;
  localparam code_t CodeI     = 5'd8;
  localparam code_t CodeJ     = 5'd9;
  localparam idx_t  IdxMax    = 3'd4;

  localparam logic [7:0] CharLowA = 8'h61;
  localparam logic [7:0] CharLowZ = 8'h7a;
  localparam logic [7:0] CharUpA  = 8'h41;
  localparam logic [7:0] CharUpZ  = 8'h5a;

  // every letter except i
  localparam logic [NumLetters-1:0] AllLetters = 26'h3fffeff;

  typedef enum logic [1:0] {
    OP_KEY    = 2'd0,
    OP_FINISH = 2'd1,
    OP_CIPHER = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL,
    ST_POS1,
    ST_POS2,
    ST_CELL1,
    ST_CELL2,
    ST_DATA2,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic [7:0] first_plain;
    logic [7:0] second_plain;
  } out_item_t;

  typedef struct packed {
    idx_t row;
    idx_t col;
  } pos_t;

  typedef struct packed {
    logic  place_en;
    code_t place_code;
    logic  pos_rd_en;
    code_t pos_rd_addr;
    logic  ks_rd_en;
    code_t ks_rd_addr;
  } sq_req_t;

  typedef struct packed {
    logic  full;
    pos_t  pos;
    code_t ks_data;
  } sq_stat_t;

  function automatic code_t cell_addr(idx_t row, idx_t col);
    return {row, 2'b00} + {2'b00, row} + {2'b00, col};
  endfunction

  // step back one place in a row or column, wrapping
  function automatic idx_t prev_idx(idx_t x);
    return (x == '0) ? IdxMax : x - 3'd1;
  endfunction

endpackage

// ===== rtl/pfd_cellsel.sv =====
// ----------------------------------------------------------------------------
// pfd_cellsel
// Decryption rule unit: maps a letter's position and its partner's position
// to the cell index of the plaintext letter. Shared by both letters of a pair.
// ----------------------------------------------------------------------------
module pfd_cellsel import pfd_pkg::*; (
  input  pos_t  own_i,
  input  pos_t  other_i,
  output code_t addr_o
);

  idx_t row, col;

  always_comb begin
    priority if (own_i.col == other_i.col) begin
      row = prev_idx(own_i.row);
      col = own_i.col;
    end else if (own_i.row == other_i.row) begin
      row = own_i.row;
      col = prev_idx(own_i.col);
    end else begin
      row = own_i.row;
      col = other_i.col;
    end
  end

  assign addr_o = cell_addr(row, col);

endmodule

// ===== rtl/pfd_square.sv =====
// ----------------------------------------------------------------------------
// pfd_square
// Key square storage: cell-to-letter table, letter-to-position table, fill
// counter and presence bits. One placement and one read per table each cycle.
// ----------------------------------------------------------------------------
module pfd_square import pfd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  sq_req_t  req_i,
  output sq_stat_t stat_o
);

  code_t ks_mem  [Cells];
  pos_t  pos_mem [NumLetters];

  code_t                 cnt_q, cnt_d;
  idx_t                  row_q, row_d;
  idx_t                  col_q, col_d;
  logic [NumLetters-1:0] present_q, present_d;
  code_t                 ks_rdata_q;
  pos_t                  pos_rdata_q;

  logic present_hit;
  logic place_ok;

  assign present_hit = (req_i.place_code < LastCode + 5'd1) ?
                       present_q[req_i.place_code] : 1'b1;

  assign place_ok = req_i.place_en && (req_i.place_code != CodeI) &&
                    !present_hit && (cnt_q != CellCount);

  always_comb begin
    cnt_d     = cnt_q;
    row_d     = row_q;
    col_d     = col_q;
    present_d = present_q;
    if (place_ok) begin
      cnt_d                        = cnt_q + 5'd1;
      present_d[req_i.place_code]  = 1'b1;
      if (col_q == IdxMax) begin
        col_d = '0;
        row_d = row_q + 3'd1;
      end else begin
        col_d = col_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      row_q     <= '0;
      col_q     <= '0;
      present_q <= '0;
    end else begin
      cnt_q     <= cnt_d;
      row_q     <= row_d;
      col_q     <= col_d;
      present_q <= present_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (place_ok) begin
      ks_mem[cnt_q]             <= req_i.place_code;
      pos_mem[req_i.place_code] <= '{row: row_q, col: col_q};
    end
    if (req_i.ks_rd_en) begin
      ks_rdata_q <= ks_mem[req_i.ks_rd_addr];
    end
    if (req_i.pos_rd_en) begin
      pos_rdata_q <= pos_mem[req_i.pos_rd_addr];
    end
  end

  assign stat_o.full    = (cnt_q == CellCount);
  assign stat_o.pos     = pos_rdata_q;
  assign stat_o.ks_data = ks_rdata_q;

`ifndef SYNTHESIS
  a_count_matches_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(present_q) == int'(cnt_q))
    else $error("presence bits disagree with fill count");

  a_fill_position: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_addr(row_q, col_q) == cnt_q)
    else $error("fill row/col out of step with fill count");

  a_full_all_letters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == CellCount) |-> (present_q == AllLetters))
    else $error("full square is missing a letter");
`endif

endmodule

// ===== rtl/pfd_seq.sv =====
// ----------------------------------------------------------------------------
// pfd_seq
// Sequencer: decodes items, steps the key fill, walks the table reads of a
// pair through the shared rule unit and holds the result register.
// ----------------------------------------------------------------------------
module pfd_seq import pfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o,
  output sq_req_t   sq_req_o,
  input  sq_stat_t  sq_stat_i
);

  state_e    state_q, state_d;
  code_t     pend_q, pend_d;
  logic      pend_valid_q, pend_valid_d;
  code_t     code_q, code_d;
  code_t     fill_q, fill_d;
  pos_t      p1_q, p1_d;
  pos_t      p2_q, p2_d;
  logic [7:0] o1_q, o1_d;
  logic [7:0] o2_q, o2_d;
  logic      out_valid_q, out_valid_d;
  out_item_t out_q, out_d;

  op_e        op;
  logic [7:0] ch;
  logic [7:0] low_diff, up_diff;
  logic       is_low, is_up;
  code_t      key_code, ciph_code;
  logic       accept;
  logic       emit_take;
  pos_t       own, other;
  code_t      cell_idx;

  assign op       = op_e'(in_data_i.opcode);
  assign ch       = in_data_i.char_in;
  assign is_low   = (ch >= CharLowA) && (ch <= CharLowZ);
  assign is_up    = (ch >= CharUpA) && (ch <= CharUpZ);
  assign low_diff = ch - CharLowA;
  assign up_diff  = ch - CharUpA;

  // i folds into j
  assign key_code  = (low_diff[CodeW-1:0] == CodeI) ? CodeJ : low_diff[CodeW-1:0];
  assign ciph_code = is_low ? key_code :
                     ((up_diff[CodeW-1:0] == CodeI) ? CodeJ : up_diff[CodeW-1:0]);

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign emit_take  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);

  // first letter's cell, then the second's with roles swapped
  assign own   = (state_q == ST_CELL1) ? p1_q : p2_q;
  assign other = (state_q == ST_CELL1) ? sq_stat_i.pos : p1_q;

  pfd_cellsel u_cellsel (
    .own_i   (own),
    .other_i (other),
    .addr_o  (cell_idx)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_FINISH: state_d = ST_FILL;
            OP_CIPHER: begin
              if ((is_low || is_up) && pend_valid_q) begin
                state_d = sq_stat_i.full ? ST_POS1 : ST_EMIT;
              end
            end
            OP_KEY, OP_NONE: state_d = ST_IDLE;
          endcase
        end
      end
      ST_FILL:  if (fill_q == LastCode) state_d = ST_IDLE;
      ST_POS1:  state_d = ST_POS2;
      ST_POS2:  state_d = ST_CELL1;
      ST_CELL1: state_d = ST_CELL2;
      ST_CELL2: state_d = ST_DATA2;
      ST_DATA2: state_d = ST_EMIT;
      ST_EMIT:  if (emit_take) state_d = ST_IDLE;
    endcase
  end

  // outputs toward the square
  always_comb begin
    sq_req_o             = '0;
    sq_req_o.place_code  = key_code;
    sq_req_o.pos_rd_addr = pend_q;
    sq_req_o.ks_rd_addr  = cell_idx;
    unique case (state_q)
      ST_IDLE:  sq_req_o.place_en = accept && (op == OP_KEY) && is_low;
      ST_FILL: begin
        sq_req_o.place_en   = 1'b1;
        sq_req_o.place_code = fill_q;
      end
      ST_POS1:  sq_req_o.pos_rd_en = 1'b1;
      ST_POS2: begin
        sq_req_o.pos_rd_en   = 1'b1;
        sq_req_o.pos_rd_addr = code_q;
      end
      ST_CELL1, ST_CELL2: sq_req_o.ks_rd_en = 1'b1;
      ST_DATA2, ST_EMIT:  sq_req_o.ks_rd_en = 1'b0;
    endcase
  end

  // datapath registers
  always_comb begin
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    code_d       = code_q;
    fill_d       = fill_q;
    p1_d         = p1_q;
    p2_d         = p2_q;
    o1_d         = o1_q;
    o2_d         = o2_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;

    if (accept && (op == OP_FINISH)) begin
      fill_d = '0;
    end
    if (accept && (op == OP_CIPHER) && (is_low || is_up)) begin
      if (!pend_valid_q) begin
        pend_d       = ciph_code;
        pend_valid_d = 1'b1;
      end else begin
        pend_valid_d = 1'b0;
        code_d       = ciph_code;
        // zeros stand when the square is not complete
        o1_d         = '0;
        o2_d         = '0;
      end
    end

    unique case (state_q)
      ST_FILL:  fill_d = fill_q + 5'd1;
      ST_POS2:  p1_d = sq_stat_i.pos;
      ST_CELL1: p2_d = sq_stat_i.pos;
      ST_CELL2: o1_d = CharLowA + {3'b000, sq_stat_i.ks_data};
      ST_DATA2: o2_d = CharLowA + {3'b000, sq_stat_i.ks_data};
      ST_EMIT: begin
        if (emit_take) begin
          out_valid_d        = 1'b1;
          out_d.first_plain  = o1_q;
          out_d.second_plain = o2_q;
        end
      end
      ST_IDLE, ST_POS1: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      pend_q       <= '0;
      pend_valid_q <= 1'b0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pend_q       <= pend_d;
      pend_valid_q <= pend_valid_d;
      fill_q       <= fill_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    o1_q   <= o1_d;
    o2_q   <= o2_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_lookup_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_POS1) |-> sq_stat_i.full)
    else $error("pair lookup started on an incomplete square");

  a_fill_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && fill_q == LastCode) |=> (state_q == ST_IDLE))
    else $error("key fill did not stop after the last letter");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_EMIT))
    else $error("result raised outside the emit step");

  a_pair_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !pend_valid_q)
    else $error("pending letter still open while emitting");
`endif

endmodule

// ===== rtl/playfair_decrypt.sv =====
// ----------------------------------------------------------------------------
// playfair_decrypt
// Playfair decryption with on-chip key square set-up.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_data_i) carries an opcode and a
//   byte: keyword byte, finish key square, or ciphertext byte. Output channel
//   (out_valid_o/out_ready_i, out_data_o) carries one plaintext letter pair
//   per completed ciphertext pair.
//   Keyword byte and single ciphertext letter: ready again next cycle.
//   Finish: codes 0 to 25, one letter code tried per cycle on the square.
//   Second letter of a pair: on a full square the result takes two position
//   reads and two cell reads, each through the single read port of its
//   table; on an incomplete one it is zero letters. The input is ready
//   again in the cycle the result register loads.
//   The result register holds an item until taken; a new item is accepted
//   meanwhile, and a further pair waits in the emit step while it is full.
//   Reset empties the square (fill count and presence bits only, no clearing
//   pass) and drops any pending letter; it takes effect at once.
// ----------------------------------------------------------------------------
module playfair_decrypt import pfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  sq_req_t  sq_req;
  sq_stat_t sq_stat;

  pfd_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .sq_req_o    (sq_req),
    .sq_stat_i   (sq_stat)
  );

  pfd_square u_square (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (sq_req),
    .stat_o (sq_stat)
  );

endmodule
